// ----- src/periodic_slot_scheduler_macros.svh -----
`ifndef PERIODIC_SLOT_SCHEDULER_MACROS_SVH
`define PERIODIC_SLOT_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSCH_ASSERT_SAME(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("periodic_slot_scheduler: port check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSCH_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("periodic_slot_scheduler: port check failed");

`endif

// ----- src/psch_pkg.sv -----
`default_nettype none

package psch_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 32;
    localparam int ENTRY_W  = PERIOD_W + TIME_W;
    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 3;
    localparam int MASK_W   = 8;
    localparam int WAIT_W   = 16;

    // stream widths, packed fields rounded up to whole bytes
    localparam int IN_FIELDS_W = 2 * TIME_W + PERIOD_W + HANDLE_W + 2;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MASK_W + WAIT_W + HANDLE_W + 1;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int REM_CNT_W = $clog2(TIME_W + 1);

    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'd50000;
    localparam logic [WAIT_W-1:0] WAIT_MIN = 16'd400;

    localparam logic [ACTION_W-1:0] ACT_SERVICE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADJUST   = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now_usec;
        logic [TIME_W-1:0]   later_usec;
        logic [PERIOD_W-1:0] interval_usec;
        logic [HANDLE_W-1:0] slot;
        logic                lock_available;
        logic                from_bus_context;
    } psch_item_t;

    typedef struct packed {
        logic [MASK_W-1:0]   fire_mask;
        logic [WAIT_W-1:0]   wait_usec;
        logic [HANDLE_W-1:0] handle;
        logic                ok;
    } psch_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REG,
        ST_ADJ,
        ST_SVC_RD,
        ST_SVC_CMP,
        ST_SVC_CATCH,
        ST_SVC_DIV,
        ST_SVC_SUB,
        ST_SVC_ADD,
        ST_SVC_UPD,
        ST_SVC_W1,
        ST_SVC_W2,
        ST_DONE
    } psch_state_t;

endpackage

`default_nettype wire

// ----- src/psch_slot_mem.sv -----
`default_nettype none

module psch_slot_mem #(
    parameter int DEPTH = psch_pkg::SLOTS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [psch_pkg::ENTRY_W-1:0] wdata,
    input  wire logic                         re,
    input  wire logic [AW-1:0]                raddr,
    output logic      [psch_pkg::ENTRY_W-1:0] rdata
);
    import psch_pkg::*;

    // entry: period in the upper bits, deadline in the lower bits
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/psch_rem_unit.sv -----
`default_nettype none

module psch_rem_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [psch_pkg::TIME_W-1:0]   dividend,
    input  wire logic [psch_pkg::PERIOD_W-1:0] divisor,
    output logic                               done,
    output logic      [psch_pkg::PERIOD_W-1:0] rem
);
    import psch_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]  dsr_reg, dsr_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;

    logic [PERIOD_W:0]    trial;
    logic                 trial_ge;
    logic [PERIOD_W-1:0]  step_rem;

    // restoring step: one dividend bit per cycle, msb first
    assign trial    = {rem_reg, dvd_reg[TIME_W-1]};
    assign trial_ge = trial >= {1'b0, dsr_reg};
    assign step_rem = trial_ge ? PERIOD_W'(trial - {1'b0, dsr_reg}) : trial[PERIOD_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = REM_CNT_W'(TIME_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == REM_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- src/psch_engine.sv -----
`default_nettype none

module psch_engine #(
    parameter int SLOTS = psch_pkg::SLOTS_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire psch_pkg::psch_item_t          item,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output psch_pkg::psch_result_t             res,
    output logic                               mem_we,
    output logic      [IDX_W-1:0]              mem_waddr,
    output logic      [psch_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic                               mem_re,
    output logic      [IDX_W-1:0]              mem_raddr,
    input  wire logic [psch_pkg::ENTRY_W-1:0]  mem_rdata,
    output logic                               rem_start,
    output logic      [psch_pkg::TIME_W-1:0]   rem_dividend,
    output logic      [psch_pkg::PERIOD_W-1:0] rem_divisor,
    input  wire logic                          rem_done,
    input  wire logic [psch_pkg::PERIOD_W-1:0] rem_value
);
    import psch_pkg::*;

    localparam int SW = (IDX_W > HANDLE_W) ? IDX_W : HANDLE_W;

    psch_state_t         state_reg, state_next;
    psch_item_t          item_reg, item_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic                due_reg, due_next;
    logic                le_reg, le_next;
    logic [TIME_W-1:0]   new_dl_reg, new_dl_next;
    logic [TIME_W-1:0]   earliest_reg, earliest_next;
    logic                any_reg, any_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    psch_result_t        res_reg, res_next;

    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [SW-1:0]       slot_w;
    logic [IDX_W-1:0]    adj_idx;
    logic                adj_in_range;
    logic                last_idx;
    psch_state_t         adv_state;
    logic [IDX_W-1:0]    adv_idx;
    logic [TIME_W-1:0]   now_plus_per;
    logic [TIME_W-1:0]   now_plus_one;
    logic [TIME_W-1:0]   dl_plus_per;
    logic [TIME_W:0]     cmp_diff;
    logic [TIME_W:0]     wait_diff;
    logic [TIME_W-1:0]   rd_dl;
    logic [PERIOD_W-1:0] rd_per;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign slot_w       = SW'(item_reg.slot);
    assign adj_idx      = slot_w[IDX_W-1:0];
    assign adj_in_range = 32'(item_reg.slot) < SLOTS;

    assign last_idx  = idx_reg == IDX_W'(SLOTS - 1);
    assign adv_state = last_idx ? ST_SVC_W1 : ST_SVC_RD;
    assign adv_idx   = last_idx ? idx_reg : idx_reg + 1'b1;

    assign now_plus_per = item_reg.now_usec + TIME_W'(item_reg.interval_usec);
    assign now_plus_one = item_reg.now_usec + TIME_W'(1);
    assign dl_plus_per  = dl_reg + TIME_W'(per_reg);

    assign rd_dl     = mem_rdata[TIME_W-1:0];
    assign rd_per    = mem_rdata[ENTRY_W-1:TIME_W];
    // borrow set means now is before the deadline
    assign cmp_diff  = {1'b0, item_reg.now_usec} - {1'b0, rd_dl};
    assign wait_diff = {1'b0, earliest_reg} - {1'b0, item_reg.later_usec};

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        dl_next       = dl_reg;
        per_next      = per_reg;
        diff_next     = diff_reg;
        due_next      = due_reg;
        le_next       = le_reg;
        new_dl_next   = new_dl_reg;
        earliest_next = earliest_reg;
        any_next      = any_reg;
        mask_next     = mask_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = {per_reg, new_dl_reg};
        mem_re        = 1'b0;
        rem_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    idx_next  = '0;
                    mask_next = '0;
                    any_next  = 1'b0;
                    unique case (item.action)
                        ACT_SERVICE:  state_next = ST_SVC_RD;
                        ACT_REGISTER: state_next = ST_REG;
                        ACT_ADJUST:   state_next = ST_ADJ;
                        default:
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_REG:
            begin
                res_next = '0;
                if (free_found)
                begin
                    valid_next[free_idx] = 1'b1;
                    mem_we          = 1'b1;
                    mem_waddr       = free_idx;
                    mem_wdata       = {item_reg.interval_usec, now_plus_per};
                    res_next.handle = HANDLE_W'(free_idx);
                    res_next.ok     = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_ADJ:
            begin
                res_next = '0;
                if (item_reg.from_bus_context && adj_in_range && valid_reg[adj_idx])
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = adj_idx;
                    mem_wdata   = {item_reg.interval_usec, now_plus_per};
                    res_next.ok = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_SVC_RD:
            begin
                if (valid_reg[idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_SVC_CMP;
                end
                else
                begin
                    idx_next   = adv_idx;
                    state_next = adv_state;
                end
            end

            ST_SVC_CMP:
            begin
                dl_next    = rd_dl;
                per_next   = rd_per;
                diff_next  = cmp_diff[TIME_W-1:0];
                due_next   = !cmp_diff[TIME_W];
                state_next = ST_SVC_CATCH;
            end

            ST_SVC_CATCH:
            begin
                state_next = ST_SVC_UPD;
                if (!due_reg)
                begin
                    new_dl_next = dl_reg;
                end
                else if (per_reg == '0)
                begin
                    new_dl_next = now_plus_one;
                end
                else if (diff_reg < TIME_W'(per_reg))
                begin
                    // within one period: a single step catches up
                    new_dl_next = dl_plus_per;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_SVC_DIV;
                end
            end

            ST_SVC_DIV:
            begin
                if (rem_done)
                begin
                    state_next = ST_SVC_SUB;
                end
            end

            ST_SVC_SUB:
            begin
                // next deadline = now - ((now - deadline) mod period) + period
                new_dl_next = item_reg.now_usec - TIME_W'(rem_value);
                state_next  = ST_SVC_ADD;
            end

            ST_SVC_ADD:
            begin
                new_dl_next = new_dl_reg + TIME_W'(per_reg);
                state_next  = ST_SVC_UPD;
            end

            ST_SVC_UPD:
            begin
                if (due_reg)
                begin
                    mem_we = 1'b1;
                    if (item_reg.lock_available)
                    begin
                        // slots past the mask width shift out to zero
                        mask_next = mask_reg | (MASK_W'(1) << idx_reg);
                    end
                end
                if (!any_reg || (new_dl_reg < earliest_reg))
                begin
                    earliest_next = new_dl_reg;
                    any_next      = 1'b1;
                end
                idx_next   = adv_idx;
                state_next = adv_state;
            end

            ST_SVC_W1:
            begin
                res_next.fire_mask = mask_reg;
                res_next.handle    = '0;
                res_next.ok        = 1'b1;
                if (!any_reg)
                begin
                    res_next.wait_usec = WAIT_MAX;
                    state_next         = ST_DONE;
                end
                else
                begin
                    diff_next  = wait_diff[TIME_W-1:0];
                    le_next    = wait_diff[TIME_W] || (wait_diff[TIME_W-1:0] == '0);
                    state_next = ST_SVC_W2;
                end
            end

            ST_SVC_W2:
            begin
                if (le_reg || (diff_reg < TIME_W'(WAIT_MIN)))
                begin
                    res_next.wait_usec = WAIT_MIN;
                end
                else if (diff_reg < TIME_W'(WAIT_MAX))
                begin
                    res_next.wait_usec = diff_reg[WAIT_W-1:0];
                end
                else
                begin
                    res_next.wait_usec = WAIT_MAX;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        dl_reg       <= dl_next;
        per_reg      <= per_next;
        diff_reg     <= diff_next;
        due_reg      <= due_next;
        le_reg       <= le_next;
        new_dl_reg   <= new_dl_next;
        earliest_reg <= earliest_next;
        any_reg      <= any_next;
        mask_reg     <= mask_next;
        res_reg      <= res_next;
    end

    assign item_ready   = state_reg == ST_IDLE;
    assign res_valid    = state_reg == ST_DONE;
    assign res          = res_reg;
    assign mem_raddr    = idx_reg;
    assign rem_dividend = diff_reg;
    assign rem_divisor  = per_reg;

endmodule

`default_nettype wire

// ----- src/periodic_slot_scheduler.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: now, later, period,
//                                               slot, lock_available, from_bus_context
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: fire_mask, wait_usec, handle, ok
//
// one transaction in at a time; a service pass skips free slots and, for each valid slot,
// reads, compares, catches up and writes back when due, then works out the wait
// a due slot that lags a full period or more also goes through the bit-serial remainder unit
// reset clears the valid bits and the handshake state; the slot memory is not cleared
// a held result sits in the output register while the next transaction is worked on

`default_nettype none

module periodic_slot_scheduler #(
    parameter int SLOTS = psch_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_usec, later_usec, interval_usec, slot, lock_available, from_bus_context, zero pad
    input  wire logic [psch_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  wire logic [psch_pkg::ACTION_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // fire_mask, wait_usec, handle, ok, zero pad
    output logic      [psch_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import psch_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    psch_item_t          item;
    psch_result_t        res;
    logic                res_valid;
    logic                res_take;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    logic                rem_start;
    logic [TIME_W-1:0]   rem_dividend;
    logic [PERIOD_W-1:0] rem_divisor;
    logic                rem_done;
    logic [PERIOD_W-1:0] rem_value;

    // output register, filled when empty or drained in the same cycle
    logic                m_valid_reg, m_valid_next;
    psch_result_t        m_res_reg, m_res_next;

    // unpack the input transaction
    assign item.action           = s_axis_tuser;
    assign item.now_usec         = s_axis_tdata[63:0];
    assign item.later_usec       = s_axis_tdata[127:64];
    assign item.interval_usec    = s_axis_tdata[159:128];
    assign item.slot             = s_axis_tdata[162:160];
    assign item.lock_available   = s_axis_tdata[163];
    assign item.from_bus_context = s_axis_tdata[164];

    psch_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_axis_tvalid),
        .item_ready   (s_axis_tready),
        .item         (item),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .rem_start    (rem_start),
        .rem_dividend (rem_dividend),
        .rem_divisor  (rem_divisor),
        .rem_done     (rem_done),
        .rem_value    (rem_value)
    );

    // period and deadline per slot, one read port, one write port
    psch_slot_mem #(
        .DEPTH (SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // (now - deadline) mod period for slots one period or more late
    psch_rem_unit u_rem_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .rem      (rem_value)
    );

    assign res_take = res_valid && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_take)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - OUT_FIELDS_W)'(0), m_res_reg.ok, m_res_reg.handle,
                            m_res_reg.wait_usec, m_res_reg.fire_mask};

endmodule

`default_nettype wire

// ----- src/psch_checker.sv -----
`default_nettype none

`include "periodic_slot_scheduler_macros.svh"

module psch_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [psch_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import psch_pkg::*;

    logic [MASK_W-1:0]   fire_mask;
    logic [WAIT_W-1:0]   wait_usec;
    logic [HANDLE_W-1:0] handle;
    logic                ok;

    assign fire_mask = m_axis_tdata[7:0];
    assign wait_usec = m_axis_tdata[23:8];
    assign handle    = m_axis_tdata[26:24];
    assign ok        = m_axis_tdata[27];

    // a stalled result holds
    `PSCH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one transaction in flight: ready drops right after an accept
    `PSCH_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // wait is zero outside service, clamped inside it
    `PSCH_ASSERT_SAME(a_wait_range, m_axis_tvalid, (wait_usec == '0) || ((wait_usec >= WAIT_MIN) && (wait_usec <= WAIT_MAX)))

    // a nonzero handle only comes from a successful register
    `PSCH_ASSERT_SAME(a_handle_reg, m_axis_tvalid && (handle != '0), ok && (wait_usec == '0) && (fire_mask == '0))

    // fired slots only come from a service pass
    `PSCH_ASSERT_SAME(a_fire_service, m_axis_tvalid && (fire_mask != '0), ok && (wait_usec != '0) && (handle == '0))

endmodule

bind periodic_slot_scheduler psch_checker u_psch_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/slot_schedule_checker.sv -----
`timescale 1ns / 100ps

module slot_schedule_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [psch_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [psch_pkg::ACTION_W-1:0]  s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [psch_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                                  failures,
    output int                                  pending
);
    import psch_pkg::*;

    localparam int SLOT_COUNT = SLOTS_DEFAULT;

    bit                  live [SLOT_COUNT];
    logic [PERIOD_W-1:0] period_of [SLOT_COUNT];
    logic [TIME_W-1:0]   due_at [SLOT_COUNT];

    psch_result_t awaited_results [$];

    // one transaction through the slot table, state updated in place
    function automatic psch_result_t schedule_step(psch_item_t it);
        psch_result_t      r;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] laps;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W-1:0] delay;
        logic [MASK_W-1:0] mask;
        bit                have_slot;
        r = '0;
        case (it.action)
            ACT_SERVICE:
            begin
                mask = '0;
                earliest = '0;
                have_slot = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!live[i])
                        continue;
                    dl = due_at[i];
                    per = {{(TIME_W-PERIOD_W){1'b0}}, period_of[i]};
                    if (it.now_usec >= dl)
                    begin
                        if (per == '0)
                            dl = it.now_usec + 64'd1;
                        else
                        begin
                            laps = (it.now_usec - dl) / per + 64'd1;
                            dl = dl + laps * per;
                        end
                        due_at[i] = dl;
                        if (it.lock_available && i < MASK_W)
                            mask[i] = 1'b1;
                    end
                    if (!have_slot || dl < earliest)
                    begin
                        earliest = dl;
                        have_slot = 1'b1;
                    end
                end
                delay = TIME_W'(WAIT_MAX);
                if (have_slot)
                begin
                    if (earliest <= it.later_usec)
                        delay = '0;
                    else if (earliest - it.later_usec < TIME_W'(WAIT_MAX))
                        delay = earliest - it.later_usec;
                end
                if (delay < TIME_W'(WAIT_MIN))
                    delay = TIME_W'(WAIT_MIN);
                r.fire_mask = mask;
                r.wait_usec = delay[WAIT_W-1:0];
                r.ok = 1'b1;
            end
            ACT_REGISTER:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!live[i])
                    begin
                        live[i] = 1'b1;
                        period_of[i] = it.interval_usec;
                        due_at[i] = it.now_usec
                                    + {{(TIME_W-PERIOD_W){1'b0}}, it.interval_usec};
                        r.handle = i[HANDLE_W-1:0];
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            ACT_ADJUST:
            begin
                if (it.from_bus_context && it.slot < SLOT_COUNT && live[it.slot])
                begin
                    period_of[it.slot] = it.interval_usec;
                    due_at[it.slot] = it.now_usec
                                      + {{(TIME_W-PERIOD_W){1'b0}}, it.interval_usec};
                    r.ok = 1'b1;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        psch_item_t   it;
        psch_result_t got;
        psch_result_t want;
        if (!rst_n)
        begin
            foreach (live[i])
                live[i] = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            // results first: a result never belongs to an item taken in the same cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.fire_mask = m_axis_tdata[MASK_W-1:0];
                got.wait_usec = m_axis_tdata[MASK_W +: WAIT_W];
                got.handle    = m_axis_tdata[MASK_W+WAIT_W +: HANDLE_W];
                got.ok        = m_axis_tdata[MASK_W+WAIT_W+HANDLE_W];
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with nothing awaited: %0h", m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("fire_mask", 64'(want.fire_mask), 64'(got.fire_mask));
                    check_field("wait_usec", 64'(want.wait_usec), 64'(got.wait_usec));
                    check_field("handle", 64'(want.handle), 64'(got.handle));
                    check_field("ok", 64'(want.ok), 64'(got.ok));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.action           = s_axis_tuser;
                it.now_usec         = s_axis_tdata[TIME_W-1:0];
                it.later_usec       = s_axis_tdata[TIME_W +: TIME_W];
                it.interval_usec    = s_axis_tdata[2*TIME_W +: PERIOD_W];
                it.slot             = s_axis_tdata[2*TIME_W+PERIOD_W +: HANDLE_W];
                it.lock_available   = s_axis_tdata[2*TIME_W+PERIOD_W+HANDLE_W];
                it.from_bus_context = s_axis_tdata[2*TIME_W+PERIOD_W+HANDLE_W+1];
                awaited_results.push_back(schedule_step(it));
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import psch_pkg::*;

    // the one action code the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    // items per random phase, four phases
    localparam int PHASE_ITEMS = 325;
    // long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // now_usec, later_usec, interval_usec, slot, lock_available, from_bus_context, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // action
    logic [ACTION_W-1:0]  s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // fire_mask, wait_usec, handle, ok, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int failures;
    int pending;

    // idle odds in percent, set per phase by the stimulus process
    int idle_pct = 0;
    int stall_pct = 0;

    // long hold-off: requested by the stimulus, run by the receiver process
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    periodic_slot_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    slot_schedule_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .pending       (pending)
    );

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // one input transaction; valid stays high into the next item unless a gap is drawn
    task automatic send(input logic [ACTION_W-1:0] action, input logic [TIME_W-1:0] now,
                        input logic [TIME_W-1:0] later, input logic [PERIOD_W-1:0] period,
                        input logic [HANDLE_W-1:0] slot, input logic lock, input logic bus);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {{(S_TDATA_W-IN_FIELDS_W){1'b0}}, bus, lock, slot, period, later, now};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [TIME_W-1:0]   sim_usec;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   later;
        logic [PERIOD_W-1:0] period;
        int                  pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        // empty table: longest wait
        send(ACT_SERVICE, 64'd0, 64'd0, 32'd0, 3'd0, 1'b1, 1'b0);
        // unknown action with every field at its top
        send(ACT_UNKNOWN, '1, '1, '1, 3'd7, 1'b1, 1'b1);
        // adjust of a slot never registered
        send(ACT_ADJUST, 64'd10, 64'd0, 32'd77, 3'd0, 1'b0, 1'b1);
        // zero period, then a normal one, then one whose deadline wraps past 2^64
        send(ACT_REGISTER, 64'd100, 64'd0, 32'd0, 3'd5, 1'b0, 1'b0);
        send(ACT_REGISTER, 64'd100, 64'd0, 32'd1000, 3'd0, 1'b1, 1'b1);
        send(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 32'd500, 3'd0, 1'b0, 1'b0);
        // zero-period slot due, wait below the floor
        send(ACT_SERVICE, 64'd200, 64'd150, 32'd0, 3'd0, 1'b1, 1'b0);
        // lock taken: nothing fires, deadlines still catch up over many periods
        send(ACT_SERVICE, 64'd5000, 64'd5000, 32'd0, 3'd0, 1'b0, 1'b0);
        // fill the table
        send(ACT_REGISTER, 64'd6000, 64'd0, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);
        send(ACT_REGISTER, 64'd6000, 64'd0, 32'd1, 3'd0, 1'b0, 1'b0);
        send(ACT_REGISTER, 64'd6000, 64'd0, 32'd7, 3'd0, 1'b0, 1'b0);
        send(ACT_REGISTER, 64'd6000, 64'd0, 32'd123456, 3'd0, 1'b0, 1'b0);
        send(ACT_REGISTER, 64'd6000, 64'd0, 32'd40000, 3'd0, 1'b0, 1'b0);
        // table full
        send(ACT_REGISTER, 64'd7000, 64'd0, 32'd9, 3'd0, 1'b1, 1'b1);
        // adjust outside bus context, then a good one
        send(ACT_ADJUST, 64'd7000, 64'd0, 32'd50, 3'd3, 1'b1, 1'b0);
        send(ACT_ADJUST, 64'd7000, 64'd0, 32'd60000, 3'd7, 1'b1, 1'b1);
        // wait held at the ceiling, then a mid-range wait
        send(ACT_SERVICE, 64'd100000, 64'd0, 32'd0, 3'd0, 1'b1, 1'b0);
        send(ACT_SERVICE, 64'd100500, 64'd100000, 32'd0, 3'd0, 1'b1, 1'b0);
        // adjust near the top of time with the largest period
        send(ACT_ADJUST, 64'hFFFF_FFFF_0000_0000, 64'd0, '1, 3'd4, 1'b1, 1'b1);
        // everything due at the last microsecond, catch-up wraps
        send(ACT_SERVICE, '1, '1, 32'd0, 3'd0, 1'b1, 1'b0);
        send(ACT_SERVICE, 64'd0, 64'd0, 32'd0, 3'd0, 1'b1, 1'b0);

        // random part: mostly well-formed traffic on a running clock, some noise
        sim_usec = 64'd1000;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default:
                begin
                    idle_pct = 32;
                    stall_pct = 32;
                    // let the running clock wrap during this phase
                    sim_usec = 64'hFFFF_FFFF_FFF8_0000;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 50)
                    hold_req = 1'b1;
                sim_usec = sim_usec + TIME_W'($urandom_range(0, 4000));
                now = sim_usec;
                case ($urandom_range(0, 9))
                    0:       period = '0;
                    1:       period = $urandom;
                    2, 3:    period = $urandom_range(3000, 100000);
                    default: period = $urandom_range(1, 3000);
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    if ($urandom_range(0, 99) < 85)
                        later = now + TIME_W'($urandom_range(0, 3000));
                    else
                        later = {$urandom, $urandom};
                    send(ACT_SERVICE, now, later, $urandom, HANDLE_W'($urandom_range(0, 7)),
                         $urandom_range(0, 99) < 80, 1'($urandom_range(0, 1)));
                end
                else if (pick < 80)
                    send(ACT_ADJUST, now, {$urandom, $urandom}, period,
                         HANDLE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 9) != 0);
                else if (pick < 88)
                    send(ACT_REGISTER, now, {$urandom, $urandom}, period,
                         HANDLE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                else if (pick < 92)
                    send(ACT_UNKNOWN, now, {$urandom, $urandom}, period,
                         HANDLE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                else
                    // noise: every field drawn over its full range
                    send(ACTION_W'($urandom_range(0, 3)), {$urandom, $urandom},
                         {$urandom, $urandom}, $urandom, HANDLE_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        s_axis_tvalid <= 1'b0;
        // let the checker count the last accepted transaction as pending
        @(posedge clk);

        // drain, then give a stray result time to show up
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/psch_pkg.sv
src/psch_slot_mem.sv
src/psch_rem_unit.sv
src/psch_engine.sv
src/periodic_slot_scheduler.sv
src/psch_checker.sv
bench/slot_schedule_checker.sv
bench/tb.sv
